// ----- rtl/phs_pkg.sv -----
package phs_pkg;

    localparam logic [31:0] C_MUL1 = 32'd747796405;
    localparam logic [31:0] C_INC  = 32'd2891336453;
    localparam logic [31:0] C_MUL2 = 32'd277803737;
    localparam logic [4:0]  C_SH_BASE = 5'd4;
    localparam int unsigned C_FOLD_SH = 22;
    localparam logic [7:0]  C_TRY_LAST = 8'd255;

    localparam logic [31:0] C_RST_LOW  = 32'sd0;
    localparam logic [31:0] C_RST_HIGH = 32'sd65536;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_SCALAR = 2'd1,
        K_TRIPLE = 2'd2,
        K_BALL   = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        A_RANGE_LOW  = 1'b0,
        A_RANGE_HIGH = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H_MUL1,
        S_H_ADD,
        S_H_MUL2,
        S_H_FOLD,
        S_SC_MUL,
        S_SC_ADD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seed_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0]        seed_after;
    } t_out_item;

endpackage

// ----- rtl/phs_mul.sv -----
module phs_mul
    import phs_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

// ----- rtl/pcg_hash_uniform_sampler_top.sv -----
// Uniform sampler on a PCG RXS-M-XS hashed 32-bit seed. Kind 0 loads the seed and
// returns no beat. Kind 1 returns low + floor((high-low)*seed/2^32) in
// signed Q16.16 after one hash advance, kind 2 a triple after three, kind 3 a
// point in the unit ball drawn from (seed>>15)-65536 per axis, redrawn while the
// squared length is >= 1.0; after 256 rejected triples it returns the origin.
// All multiplies run through one registered 32x32 multiplier under a sequencer:
// each component steps through H_MUL1, H_ADD, H_MUL2 and H_FOLD, then SC_MUL and
// SC_ADD (or SQ_MUL and SQ_ACC for kind 3), and S_DONE registers the result.
// The block takes no new beat while a request is in flight; a finished result
// waits in S_DONE until the output register is free.
module pcg_hash_uniform_sampler_top
    import phs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state      r_state, n_state;
    logic [31:0] r_low, r_high, r_seed, r_s;
    logic [1:0]  r_kind, r_comp;
    logic [7:0]  r_try;
    logic [33:0] r_len;
    logic [16:0] r_cabs;
    logic [31:0] r_vals [3];
    t_out_item   r_out;
    logic        r_out_valid;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic        in_fire, out_free, last_comp, is_ball;
    logic [4:0]  sh;
    logic [31:0] xs, w, fold, new_seed_comp;
    logic [32:0] d, mag33;
    logic        neg;
    logic [32:0] t;
    logic [32:0] sample;
    logic [17:0] ball_c;
    logic [33:0] len_new;

    phs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_ball   = (r_kind == K_BALL);
    assign last_comp = (r_kind == K_SCALAR) ? 1'b1 : (r_comp == 2'd2);

    assign sh   = {1'b0, r_s[31:28]} + C_SH_BASE;
    assign xs   = (r_s >> sh) ^ r_s;
    assign w    = mul_p[31:0];
    assign fold = w ^ (w >> C_FOLD_SH);
    assign new_seed_comp = fold;
    assign ball_c = {1'b0, new_seed_comp[31:15]} - 18'sd65536;

    assign d     = {r_high[31], r_high} - {r_low[31], r_low};
    assign neg   = d[32];
    assign mag33 = neg ? (33'd0 - d) : d;
    assign t     = neg ? (33'd0 - ({1'b0, mul_p[63:32]}
                                  + {32'd0, (mul_p[31:0] != 32'd0)}))
                       : {1'b0, mul_p[63:32]};
    assign sample = {r_low[31], r_low} + t;
    assign len_new = r_len + mul_p[33:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_fire && i_in_data.kind != K_LOAD) n_state = S_H_MUL1;
            S_H_MUL1: n_state = S_H_ADD;
            S_H_ADD:  n_state = S_H_MUL2;
            S_H_MUL2: n_state = S_H_FOLD;
            S_H_FOLD: n_state = is_ball ? S_SQ_MUL : S_SC_MUL;
            S_SC_MUL: n_state = S_SC_ADD;
            S_SC_ADD: n_state = last_comp ? S_DONE : S_H_MUL1;
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (!last_comp) begin
                    n_state = S_H_MUL1;
                end else if (len_new[33:32] == 2'd0 || r_try == C_TRY_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_H_MUL1;
                end
            end
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_H_MUL1: begin
                mul_a = r_seed;
                mul_b = C_MUL1;
            end
            S_H_MUL2: begin
                mul_a = xs;
                mul_b = C_MUL2;
            end
            S_SC_MUL: begin
                mul_a = mag33[31:0];
                mul_b = r_seed;
            end
            S_SQ_MUL: begin
                mul_a = {15'd0, r_cabs};
                mul_b = {15'd0, r_cabs};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= C_RST_LOW;
            r_high      <= C_RST_HIGH;
            r_seed      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                if (paddr[2] == A_RANGE_HIGH) r_high <= pwdata;
                else                          r_low  <= pwdata;
            end
            if (r_out_valid && i_out_ready && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.kind == K_LOAD) r_seed <= i_in_data.seed_value;
                        r_kind    <= i_in_data.kind;
                        r_comp    <= 2'd0;
                        r_try     <= 8'd0;
                        r_len     <= 34'd0;
                        r_vals[0] <= 32'd0;
                        r_vals[1] <= 32'd0;
                        r_vals[2] <= 32'd0;
                    end
                end
                S_H_ADD:  r_s <= w + C_INC;
                S_H_FOLD: begin
                    r_seed <= fold;
                    r_vals[r_comp] <= {{14{ball_c[17]}}, ball_c};
                    r_cabs <= ball_c[17] ? 17'(18'd0 - ball_c) : ball_c[16:0];
                end
                S_SC_ADD: begin
                    r_vals[r_comp] <= sample[31:0];
                    if (!last_comp) r_comp <= r_comp + 2'd1;
                end
                S_SQ_ACC: begin
                    if (!last_comp) begin
                        r_comp <= r_comp + 2'd1;
                        r_len  <= len_new;
                    end else if (len_new[33:32] != 2'd0) begin
                        if (r_try == C_TRY_LAST) begin
                            r_vals[0] <= 32'd0;
                            r_vals[1] <= 32'd0;
                            r_vals[2] <= 32'd0;
                        end else begin
                            r_try  <= r_try + 8'd1;
                            r_comp <= 2'd0;
                            r_len  <= 34'd0;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.value_x    <= r_vals[0];
                        r_out.value_y    <= r_vals[1];
                        r_out.value_z    <= r_vals[2];
                        r_out.seed_after <= r_seed;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == A_RANGE_HIGH) ? r_high : r_low;

    a_load_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.kind == K_LOAD)
        |=> (r_seed == $past(i_in_data.seed_value)) && o_in_ready)
        else $error("seed load lost");

    a_ball_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && is_ball)
        |-> (o_out_data.value_x >= -32'sd65536) && (o_out_data.value_x < 32'sd65536)
         && (o_out_data.value_y >= -32'sd65536) && (o_out_data.value_y < 32'sd65536)
         && (o_out_data.value_z >= -32'sd65536) && (o_out_data.value_z < 32'sd65536))
        else $error("ball component out of range");

    a_scalar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && r_kind == K_SCALAR)
        |-> (o_out_data.value_y == 32'sd0) && (o_out_data.value_z == 32'sd0))
        else $error("scalar result has nonzero y or z");

endmodule

// ----- tb/pcg_hash_uniform_sampler_top_test.sv -----
`timescale 1ns / 100ps

module pcg_hash_uniform_sampler_top_test;
    import phs_pkg::*;

    localparam logic [31:0] LCG_MULT   = 32'd747796405;
    localparam logic [31:0] LCG_INC    = 32'd2891336453;
    localparam logic [31:0] RXS_MULT   = 32'd277803737;
    localparam int          BALL_TRIES = 256;
    localparam logic [31:0] UNIT_NEG   = 32'hFFFF_0000;
    localparam logic [31:0] UNIT_POS   = 32'h0001_0000;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          CYCLE_LIMIT   = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pcg_hash_uniform_sampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // sampler state as predicted
    logic [31:0] model_seed = '0;
    logic [31:0] model_low  = C_RST_LOW;
    logic [31:0] model_high = C_RST_HIGH;

    t_out_item   pending_samples[$];
    int          mismatches = 0;
    longint      cycle_count = 0;

    bit          src_calm = 1'b0;
    bit          valid_held = 1'b0;
    int          sink_hold_left = 0;
    int          sink_stall_left = 0;
    int          sink_calm_left = 0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pcg_hash_uniform_sampler_top_test NOT OK");
            $finish;
        end
    end

    // advance seed, then low + floor((high - low) * seed / 2^32)
    function automatic logic [31:0] draw_in_range(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] s;
        logic [31:0] w;
        longint      d;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      t;
        longint      sum;
        s = model_seed * LCG_MULT + LCG_INC;
        w = ((s >> (int'(s[31:28]) + 4)) ^ s) * RXS_MULT;
        model_seed = (w >> 22) ^ w;
        d = longint'(signed'(hi)) - longint'(signed'(lo));
        if (d >= 0) begin
            mag = d;
            prod = mag * {32'h0, model_seed};
            t = longint'(prod >> 32);
        end else begin
            mag = -d;
            prod = mag * {32'h0, model_seed};
            t = -longint'((prod >> 32) + (prod[31:0] != 32'h0));
        end
        sum = longint'(signed'(lo)) + t;
        return sum[31:0];
    endfunction

    function automatic bit predict_item(input t_in_item it, output t_out_item res);
        longint      len2;
        bit          found;
        res = '0;
        case (t_kind'(it.kind))
            K_LOAD: begin
                model_seed = it.seed_value;
                return 1'b0;
            end
            K_SCALAR: begin
                res.value_x = draw_in_range(model_low, model_high);
            end
            K_TRIPLE: begin
                res.value_x = draw_in_range(model_low, model_high);
                res.value_y = draw_in_range(model_low, model_high);
                res.value_z = draw_in_range(model_low, model_high);
            end
            default: begin
                found = 1'b0;
                for (int tries = 0; tries < BALL_TRIES && !found; tries++) begin
                    res.value_x = draw_in_range(UNIT_NEG, UNIT_POS);
                    res.value_y = draw_in_range(UNIT_NEG, UNIT_POS);
                    res.value_z = draw_in_range(UNIT_NEG, UNIT_POS);
                    len2 = longint'(res.value_x) * longint'(res.value_x)
                         + longint'(res.value_y) * longint'(res.value_y)
                         + longint'(res.value_z) * longint'(res.value_z);
                    found = (len2 < 64'sh1_0000_0000);
                end
                if (!found) begin
                    res.value_x = '0;
                    res.value_y = '0;
                    res.value_z = '0;
                end
            end
        endcase
        res.seed_after = model_seed;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // output beat checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                note_mismatch("unexpected beat, seed_after", 32'h0, o_out_data.seed_after);
            end else begin
                want = pending_samples.pop_front();
                if (o_out_data.value_x !== want.value_x)
                    note_mismatch("value_x", want.value_x, o_out_data.value_x);
                if (o_out_data.value_y !== want.value_y)
                    note_mismatch("value_y", want.value_y, o_out_data.value_y);
                if (o_out_data.value_z !== want.value_z)
                    note_mismatch("value_z", want.value_z, o_out_data.value_z);
                if (o_out_data.seed_after !== want.seed_after)
                    note_mismatch("seed_after", want.seed_after, o_out_data.seed_after);
            end
        end
    end

    // output ready: long holds on request, random stalls, calm stretches
    always @(posedge i_clk) begin
        int r;
        if (sink_hold_left > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else if (sink_calm_left > 0) begin
            i_out_ready <= 1'b1;
            sink_calm_left = sink_calm_left - 1;
        end else if (sink_stall_left > 0) begin
            i_out_ready <= 1'b0;
            sink_stall_left = sink_stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                i_out_ready <= 1'b1;
                sink_calm_left = $urandom_range(20, 200);
            end else if (r < 60) begin
                i_out_ready <= 1'b1;
            end else if (r < 92) begin
                i_out_ready <= 1'b0;
                sink_stall_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                sink_stall_left = $urandom_range(10, 50);
            end
        end
    end

    task automatic send_item(input t_kind kind, input logic [31:0] seed);
        t_in_item  it;
        t_out_item res;
        int        gap;
        int        r;
        it.kind = kind;
        it.seed_value = seed;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_item(it, res))
            pending_samples.push_back(res);
        r = $urandom_range(0, 99);
        if (src_calm || r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        valid_held = (gap == 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_block();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit is_write, input t_reg_idx idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (is_write) begin
            if (idx == A_RANGE_LOW) model_low = wdata;
            else model_high = wdata;
        end
    endtask

    task automatic set_range(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] rd;
        drain_block();
        apb_xfer(1'b1, A_RANGE_LOW, lo, rd);
        apb_xfer(1'b1, A_RANGE_HIGH, hi, rd);
        apb_xfer(1'b0, A_RANGE_LOW, '0, rd);
        if (rd !== model_low) note_mismatch("range_low readback", model_low, rd);
        apb_xfer(1'b0, A_RANGE_HIGH, '0, rd);
        if (rd !== model_high) note_mismatch("range_high readback", model_high, rd);
    endtask

    function automatic t_kind random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return K_LOAD;
        if (r < 50) return K_SCALAR;
        if (r < 80) return K_TRIPLE;
        return K_BALL;
    endfunction

    // reset seed and default range [0, 1.0)
    task automatic test_reset_state();
        send_item(K_SCALAR, $urandom);
        send_item(K_TRIPLE, $urandom);
        send_item(K_BALL, $urandom);
    endtask

    task automatic test_seed_load();
        send_item(K_LOAD, 32'h0000_0000);
        send_item(K_SCALAR, $urandom);
        send_item(K_LOAD, 32'hFFFF_FFFF);
        send_item(K_SCALAR, $urandom);
        send_item(K_LOAD, 32'h8000_0000);
        send_item(K_TRIPLE, $urandom);
        send_item(K_LOAD, 32'h0000_0001);
    endtask

    task automatic test_range_extremes();
        set_range(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(K_SCALAR, $urandom);
        send_item(K_TRIPLE, $urandom);
        set_range(32'h1234_5678, 32'h1234_5678);
        send_item(K_SCALAR, $urandom);
        send_item(K_BALL, $urandom);
    endtask

    // high below low: samples fall in [high, low]
    task automatic test_reversed_range();
        set_range(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(K_SCALAR, $urandom);
        send_item(K_TRIPLE, $urandom);
        set_range(32'h0001_0000, 32'hFFFF_0000);
        send_item(K_TRIPLE, $urandom);
    endtask

    task automatic test_unit_ball();
        send_item(K_LOAD, $urandom);
        repeat (4) send_item(K_BALL, $urandom);
    endtask

    // sink held off while the source keeps offering beats
    task automatic test_backpressure();
        set_range(C_RST_LOW, C_RST_HIGH);
        sink_hold_left <= 400;
        src_calm = 1'b1;
        repeat (16) send_item(random_kind(), $urandom);
        src_calm = 1'b0;
        drain_block();
    endtask

    task automatic test_random_mix();
        logic [31:0] lo;
        logic [31:0] hi;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin lo = C_RST_LOW; hi = C_RST_HIGH; end
                1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                2: begin lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; end
                4: begin
                    lo = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
                    hi = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
                end
                6: begin lo = C_RST_LOW; hi = C_RST_HIGH; end
                default: begin lo = $urandom; hi = $urandom; end
            endcase
            set_range(lo, hi);
            for (int n = 0; n < 250; n++) begin
                if (n % 50 == 0) src_calm = ($urandom_range(0, 3) == 0);
                send_item(random_kind(), $urandom);
            end
            src_calm = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_seed_load();
        test_range_extremes();
        test_reversed_range();
        test_unit_ball();
        test_backpressure();
        test_random_mix();
        drain_block();
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("pcg_hash_uniform_sampler_top_test OK");
        end else begin
            $display("pcg_hash_uniform_sampler_top_test NOT OK");
        end
        $finish;
    end

endmodule
